// ===== hdl/psr_pkg.sv =====
// shared types, request codes and field constants for the scroll address registers
// no dependencies
package psr_pkg;

  // request codes on in_req_type
  localparam logic [2:0] REQ_REG_WRITE   = 3'd0;
  localparam logic [2:0] REQ_STATUS_READ = 3'd1;
  localparam logic [2:0] REQ_DATA_ACCESS = 3'd2;
  localparam logic [2:0] REQ_COARSE_X    = 3'd3;
  localparam logic [2:0] REQ_VERT_INC    = 3'd4;
  localparam logic [2:0] REQ_COPY_HORIZ  = 3'd5;
  localparam logic [2:0] REQ_COPY_VERT   = 3'd6;

  // register indexes for a register write
  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDRESS = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // field limits
  localparam logic [4:0] COARSE_LAST   = 5'd31;
  localparam logic [4:0] COARSE_Y_WRAP = 5'd29;
  localparam logic [2:0] FINE_Y_LAST   = 3'd7;
  localparam logic [14:0] STEP_ROW     = 15'd32;
  localparam logic [14:0] STEP_ONE     = 15'd1;

  // one input beat
  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic       peek_only;
  } item_t;

  // architectural state
  typedef struct packed {
    logic [14:0] vaddr;
    logic [14:0] taddr;
    logic [2:0]  fine_x;
    logic        toggle;
    logic [7:0]  ctrl;
    logic [7:0]  mask;
  } state_t;

endpackage

// ===== hdl/psr_update.sv =====
// next-state logic for one item: register writes, status read, data port step and render events
// depends on psr_pkg
module psr_update import psr_pkg::*; (
  input  state_t      cur,
  input  item_t       item,
  output state_t      nxt,
  output logic [13:0] access_address
);

  logic        render;
  logic [14:0] step;
  logic [14:0] stepped;
  logic [4:0]  coarse_y;

  assign render   = |cur.mask[4:3];
  assign step     = cur.ctrl[2] ? STEP_ROW : STEP_ONE;
  assign stepped  = {1'b0, cur.vaddr[13:0]} + step;
  assign coarse_y = cur.vaddr[9:5];

  // decode the item and update the fields it touches
  always_comb begin
    nxt            = cur;
    access_address = '0;
    unique case (item.req_type)
      REQ_REG_WRITE: begin
        unique case (item.reg_index)
          REG_CONTROL: begin
            nxt.ctrl         = item.write_data;
            nxt.taddr[11:10] = item.write_data[1:0];
          end
          REG_MASK: begin
            nxt.mask = item.write_data;
          end
          REG_SCROLL: begin
            if (cur.toggle) begin
              nxt.taddr[14:12] = item.write_data[2:0];
              nxt.taddr[9:5]   = item.write_data[7:3];
            end else begin
              nxt.fine_x      = item.write_data[2:0];
              nxt.taddr[4:0]  = item.write_data[7:3];
            end
            nxt.toggle = ~cur.toggle;
          end
          REG_ADDRESS: begin
            if (cur.toggle) begin
              nxt.taddr[7:0] = item.write_data;
              nxt.vaddr      = {cur.taddr[14:8], item.write_data};
            end else begin
              nxt.taddr[14]   = 1'b0;
              nxt.taddr[13:8] = item.write_data[5:0];
            end
            nxt.toggle = ~cur.toggle;
          end
          REG_DATA: begin
            access_address = cur.vaddr[13:0];
            nxt.vaddr      = stepped;
          end
          default: ;
        endcase
      end
      REQ_STATUS_READ: begin
        nxt.toggle = 1'b0;
      end
      REQ_DATA_ACCESS: begin
        access_address = cur.vaddr[13:0];
        if (!item.peek_only) nxt.vaddr = stepped;
      end
      REQ_COARSE_X: begin
        if (render) begin
          if (cur.vaddr[4:0] == COARSE_LAST) begin
            nxt.vaddr[4:0] = '0;
            nxt.vaddr[10]  = ~cur.vaddr[10];
          end else begin
            nxt.vaddr = cur.vaddr + STEP_ONE;
          end
        end
      end
      REQ_VERT_INC: begin
        if (render) begin
          if (cur.vaddr[14:12] != FINE_Y_LAST) begin
            nxt.vaddr[14:12] = cur.vaddr[14:12] + 3'd1;
          end else begin
            nxt.vaddr[14:12] = '0;
            if (coarse_y == COARSE_Y_WRAP) begin
              nxt.vaddr[9:5] = '0;
              nxt.vaddr[11]  = ~cur.vaddr[11];
            end else if (coarse_y == COARSE_LAST) begin
              nxt.vaddr[9:5] = '0;
            end else begin
              nxt.vaddr[9:5] = coarse_y + 5'd1;
            end
          end
        end
      end
      REQ_COPY_HORIZ: begin
        if (render) begin
          nxt.vaddr[10]  = cur.taddr[10];
          nxt.vaddr[4:0] = cur.taddr[4:0];
        end
      end
      REQ_COPY_VERT: begin
        if (render) begin
          nxt.vaddr[14:11] = cur.taddr[14:11];
          nxt.vaddr[9:5]   = cur.taddr[9:5];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/ppu_scroll_address_registers_core.sv =====
// top level of the scroll address registers: input register, state, result register
// depends on psr_pkg and psr_update
//
// Takes one beat per clock cycle while not stalled: a beat lands in the input
// register, and is then applied to the address state and written to the result
// register together with the updated state. The state register loops back through
// the combinational psr_update, so consecutive beats flow back to back; the input
// stage keeps accepting while a result waits, and stalls only when both the input
// register and the result register are full and the result is not taken.
module ppu_scroll_address_registers_core import psr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_reg_index,
  input  logic [7:0]  in_write_data,
  input  logic        in_peek_only,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_access_address,
  output logic [14:0] out_vram_address,
  output logic [14:0] out_temp_address,
  output logic [2:0]  out_fine_scroll_x,
  output logic        out_toggle_out
);

  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        s1_fire;
  state_t      state_r;
  state_t      state_nxt;
  logic [13:0] acc_nxt;
  logic        out_valid_r;
  logic [13:0] out_acc_r;
  state_t      out_state_r;

  // handshake: stage advances when the result register is free or draining
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= '{req_type:   in_req_type,
                     reg_index:  in_reg_index,
                     write_data: in_write_data,
                     peek_only:  in_peek_only};
    end
  end

  psr_update u_update (
    .cur            (state_r),
    .item           (s1_item_r),
    .nxt            (state_nxt),
    .access_address (acc_nxt)
  );

  // address state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_acc_r   <= acc_nxt;
      out_state_r <= state_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_access_address = out_acc_r;
  assign out_vram_address   = out_state_r.vaddr;
  assign out_temp_address   = out_state_r.taddr;
  assign out_fine_scroll_x  = out_state_r.fine_x;
  assign out_toggle_out     = out_state_r.toggle;

`ifndef SYNTHESIS
  // a status read always leaves the toggle clear
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item_r.req_type == REQ_STATUS_READ |=> !state_r.toggle)
    else $error("toggle not cleared by status read");

  // second address write copies temp into the current address
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item_r.req_type == REQ_REG_WRITE &&
    s1_item_r.reg_index == REG_ADDRESS && state_r.toggle |=>
    state_r.vaddr == state_r.taddr)
    else $error("address write did not load current address");

  // access address only carries data for data port beats
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item_r.req_type != REQ_DATA_ACCESS &&
    !(s1_item_r.req_type == REQ_REG_WRITE && s1_item_r.reg_index == REG_DATA) |=>
    out_access_address == '0)
    else $error("access address set on non data beat");

  // result register mirrors the state after each beat
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_vram_address == state_r.vaddr && out_temp_address == state_r.taddr)
    else $error("result does not match state");
`endif

endmodule
